FILE: sv/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants for the HMAC-SHA256 engine
// Holds the SHA-256 round constants, the initial value, and the command and
// status structs between controller and datapath.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int KeyWords = 8;
  localparam int CfgAddrW = 6;
  localparam int CfgDataW = 64;
  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5c;
  localparam logic [7:0] PadByte  = 8'h80;

  typedef logic [31:0] word_t;

  // Source of the block that the next compression works on.
  typedef enum logic [2:0] {
    SRC_IPAD,
    SRC_OPAD,
    SRC_MSG,
    SRC_PAD1,
    SRC_PADL,
    SRC_OUTER
  } blk_src_t;

  typedef struct packed {
    logic     init_iv;
    logic     start;
    blk_src_t src;
    logic     save_inner;
    logic     set_len_key;
    logic     cap_byte;
    logic     put_byte;
    logic     clr_buf;
  } dp_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       full_after;
    logic       long_tail;
  } dp_sts_t;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t StartValue [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

FILE: sv/hse_stream_if.sv
// ----------------------------------------------------------------------------
// hse_in_if / hse_out_if: valid-ready channels of the HMAC-SHA256 engine
// A beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface hse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;
  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink (input valid, data_byte, byte_present, last_byte, output ready);
  modport monitor (input valid, ready, data_byte, byte_present, last_byte);
endinterface

interface hse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mac_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, mac_word, word_index, last_word, input ready);
  modport sink (input valid, mac_word, word_index, last_word, output ready);
  modport monitor (input valid, ready, mac_word, word_index, last_word);
endinterface

FILE: sv/hmac_sha256_engine_top.sv
// Sequence: each message byte is captured in ST_IDLE and written in ST_BYTE; the
// item that opens a message first compresses the key block, and a byte that
// completes a block adds one compression. A final item runs three more
// compressions (four when the length needs its own block) before the MAC words.
// Throughput: one item at a time; the single SHA-256 round loop sets it.
// Reset: rst_n synchronous, clears keys, length and control; no message open.
// ----------------------------------------------------------------------------
// hmac_sha256_engine_top: HMAC-SHA256 over a byte stream
// Holds the key registers on an APB-style port and joins controller and
// datapath.
// ----------------------------------------------------------------------------
module hmac_sha256_engine_top (
  input  logic                         clk,
  input  logic                         rst_n,
  hse_in_if.sink                       in_ch,
  hse_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [hse_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [hse_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [hse_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                         cfg_pready
);

  logic [hse_pkg::CfgDataW-1:0] key_r [hse_pkg::KeyWords];
  hse_pkg::dp_cmd_t cmd;
  hse_pkg::dp_sts_t sts;
  hse_pkg::word_t   digest [8];

  // Key registers, one per 8-byte slot.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = key_r[cfg_paddr[5:3]];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hse_pkg::KeyWords; i++) key_r[i] <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      key_r[cfg_paddr[5:3]] <= cfg_pwdata;
    end
  end

  hse_controller u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .sts(sts), .digest(digest), .cmd(cmd)
  );

  hse_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .data_byte(in_ch.data_byte),
    .key_word(key_r), .sts(sts), .digest(digest)
  );

endmodule

FILE: sv/hse_datapath.sv
// ----------------------------------------------------------------------------
// hse_datapath: SHA-256 round engine, block buffer and length counter
// Runs one SHA-256 round per cycle over a 16-word message schedule window.
// ----------------------------------------------------------------------------
module hse_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hse_pkg::dp_cmd_t              cmd,
  input  logic [7:0]                    data_byte,
  input  logic [hse_pkg::CfgDataW-1:0]  key_word [hse_pkg::KeyWords],
  output hse_pkg::dp_sts_t              sts,
  output hse_pkg::word_t                digest [8]
);

  // Chaining value, working variables, schedule window and block buffer.
  hse_pkg::word_t cv_r [8];
  hse_pkg::word_t v_r [8];
  hse_pkg::word_t w_r [16];
  hse_pkg::word_t inner_r [8];
  hse_pkg::word_t buf_r [16];
  logic [7:0]     byte_r;
  logic [63:0]    len_r;
  logic [6:0]     rnd_r;
  logic           busy_r;

  function automatic hse_pkg::word_t rotr(hse_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Block chosen by the command, as sixteen big-endian words.
  hse_pkg::word_t blk [16];
  hse_pkg::word_t pad_blk [16];
  logic [5:0]     used;
  logic [63:0]    bits;
  always_comb begin
    used = len_r[5:0];
    bits = {len_r[60:0], 3'b000};
    for (int i = 0; i < 16; i++) begin
      blk[i] = '0;
    end
    unique case (cmd.src)
      hse_pkg::SRC_IPAD, hse_pkg::SRC_OPAD: begin
        for (int i = 0; i < 16; i++) begin
          blk[i] = (i[0] ? key_word[i/2][31:0] : key_word[i/2][63:32])
                   ^ {4{(cmd.src == hse_pkg::SRC_IPAD) ?
                         hse_pkg::IpadByte : hse_pkg::OpadByte}};
        end
      end
      hse_pkg::SRC_MSG, hse_pkg::SRC_PAD1, hse_pkg::SRC_PADL: begin
        for (int i = 0; i < 16; i++) begin
          blk[i] = buf_r[i];
        end
        if (cmd.src == hse_pkg::SRC_PADL) begin
          blk[14] = bits[63:32];
          blk[15] = bits[31:0];
        end
      end
      hse_pkg::SRC_OUTER: begin
        for (int i = 0; i < 8; i++) begin
          blk[i] = inner_r[i];
        end
        blk[8]  = 32'h8000_0000;
        blk[15] = 32'd768;
      end
      default: ;
    endcase
  end

  // Buffer with 0x80 after the last byte and zeros beyond it.
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      if (6'(i) == used) pad_blk[i/4][31-8*(i%4) -: 8] = hse_pkg::PadByte;
      else if (6'(i) > used) pad_blk[i/4][31-8*(i%4) -: 8] = 8'h00;
      else pad_blk[i/4][31-8*(i%4) -: 8] = buf_r[i/4][31-8*(i%4) -: 8];
    end
  end

  // One round: compression step and schedule shift.
  hse_pkg::word_t t1, t2, wn, s0, s1;
  always_comb begin
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
         + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + hse_pkg::RoundK[rnd_r[5:0]] + w_r[0];
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
      len_r  <= '0;
    end else begin
      if (cmd.init_iv) begin
        for (int i = 0; i < 8; i++) cv_r[i] <= hse_pkg::StartValue[i];
      end
      if (cmd.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        for (int i = 0; i < 8; i++) begin
          v_r[i] <= cmd.init_iv ? hse_pkg::StartValue[i] : cv_r[i];
        end
        for (int i = 0; i < 16; i++) w_r[i] <= blk[i];
      end else if (busy_r) begin
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wn;
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == 7'd63) begin
          busy_r <= 1'b0;
          cv_r[0] <= cv_r[0] + t1 + t2;
          cv_r[4] <= cv_r[4] + v_r[3] + t1;
          for (int i = 1; i < 8; i++) begin
            if (i != 4) cv_r[i] <= cv_r[i] + v_r[i-1];
          end
        end
      end
      if (cmd.save_inner) begin
        for (int i = 0; i < 8; i++) inner_r[i] <= cv_r[i];
      end
      if (cmd.cap_byte) byte_r <= data_byte;
      if (cmd.set_len_key) len_r <= 64'd64;
      else if (cmd.put_byte) len_r <= len_r + 64'd1;
      // Byte write, padding of the tail, or clearing for the length block.
      if (cmd.put_byte) begin
        buf_r[used[5:2]][31-8*used[1:0] -: 8] <= byte_r;
      end else if (cmd.clr_buf) begin
        for (int i = 0; i < 16; i++) buf_r[i] <= pad_blk[i];
      end else if (cmd.src == hse_pkg::SRC_PAD1 && cmd.start) begin
        for (int i = 0; i < 16; i++) buf_r[i] <= '0;
      end
    end
  end

  assign sts.busy       = busy_r;
  assign sts.full_after = (len_r[5:0] == 6'd63);
  assign sts.long_tail  = (len_r[5:0] >= 6'd56);
  assign digest         = cv_r;

endmodule

FILE: sv/hse_controller.sv
// ----------------------------------------------------------------------------
// hse_controller: sequencer for the inner and outer hash passes
// Accepts items, orders the compressions and emits the eight MAC words.
// ----------------------------------------------------------------------------
module hse_controller (
  input  logic             clk,
  input  logic             rst_n,
  hse_in_if.sink           in_ch,
  hse_out_if.source        out_ch,
  input  hse_pkg::dp_sts_t sts,
  input  hse_pkg::word_t   digest [8],
  output hse_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_IPAD, ST_BYTE, ST_MSGC, ST_PAD, ST_PAD1, ST_PADL,
    ST_OPAD, ST_OUTER, ST_WAIT, ST_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic       open_r, open_nxt;
  logic       pend_byte_r, pend_byte_nxt;
  logic       pend_last_r, pend_last_nxt;
  logic [2:0] idx_r, idx_nxt;
  state_t     ret_r, ret_nxt;
  logic       accept;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = (state_r == ST_EMIT);
  assign out_ch.mac_word   = digest[idx_r];
  assign out_ch.word_index = idx_r;
  assign out_ch.last_word  = (idx_r == 3'd7);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r; open_nxt = open_r; idx_nxt = idx_r; ret_nxt = ret_r;
    pend_byte_nxt = pend_byte_r; pend_last_nxt = pend_last_r;
    cmd = '0;
    cmd.src = hse_pkg::SRC_MSG;
    unique case (state_r)
      ST_IDLE: begin
        cmd.cap_byte = accept;
        if (accept && (in_ch.byte_present || in_ch.last_byte)) begin
          pend_byte_nxt = in_ch.byte_present;
          pend_last_nxt = in_ch.last_byte;
          if (!open_r) begin
            cmd.init_iv = 1'b1; cmd.start = 1'b1; cmd.src = hse_pkg::SRC_IPAD;
            cmd.set_len_key = 1'b1; open_nxt = 1'b1;
            state_nxt = ST_WAIT; ret_nxt = ST_BYTE;
          end else begin
            state_nxt = ST_BYTE;
          end
        end
      end
      ST_BYTE: begin
        if (pend_byte_r) begin
          cmd.put_byte = 1'b1;
          state_nxt = sts.full_after ? ST_MSGC : (pend_last_r ? ST_PAD : ST_IDLE);
        end else begin
          state_nxt = pend_last_r ? ST_PAD : ST_IDLE;
        end
      end
      ST_MSGC: begin
        cmd.start = 1'b1; cmd.src = hse_pkg::SRC_MSG;
        state_nxt = ST_WAIT; ret_nxt = pend_last_r ? ST_PAD : ST_IDLE;
      end
      ST_PAD: begin
        cmd.clr_buf = 1'b1;
        state_nxt = sts.long_tail ? ST_PAD1 : ST_PADL;
      end
      ST_PAD1: begin
        cmd.start = 1'b1; cmd.src = hse_pkg::SRC_PAD1;
        state_nxt = ST_WAIT; ret_nxt = ST_PADL;
      end
      ST_PADL: begin
        cmd.start = 1'b1; cmd.src = hse_pkg::SRC_PADL;
        state_nxt = ST_WAIT; ret_nxt = ST_OPAD;
      end
      ST_OPAD: begin
        cmd.save_inner = 1'b1; cmd.init_iv = 1'b1; cmd.start = 1'b1;
        cmd.src = hse_pkg::SRC_OPAD;
        state_nxt = ST_WAIT; ret_nxt = ST_OUTER;
      end
      ST_OUTER: begin
        cmd.start = 1'b1; cmd.src = hse_pkg::SRC_OUTER;
        state_nxt = ST_WAIT; ret_nxt = ST_EMIT; idx_nxt = '0;
      end
      ST_WAIT: begin
        if (!sts.busy) state_nxt = ret_r;
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            state_nxt = ST_IDLE; open_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; open_r <= 1'b0; idx_r <= '0; ret_r <= ST_IDLE;
      pend_byte_r <= 1'b0; pend_last_r <= 1'b0;
    end else begin
      state_r <= state_nxt; open_r <= open_nxt; idx_r <= idx_nxt; ret_r <= ret_nxt;
      pend_byte_r <= pend_byte_nxt; pend_last_r <= pend_last_nxt;
    end
  end

endmodule

FILE: sv/hse_checker.sv
// ----------------------------------------------------------------------------
// hse_checker: port-level checks for the HMAC-SHA256 engine
// Watches the result channel, the input ready and the configuration port.
// ----------------------------------------------------------------------------
module hse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_word_index,
  input logic        out_last_word,
  input logic        in_ready,
  input logic        cfg_pready
);

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last word flag mismatch");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("word order broken");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("input taken while emitting");
  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind hmac_sha256_engine_top hse_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_word_index(out_ch.word_index), .out_last_word(out_ch.last_word),
  .in_ready(in_ch.ready), .cfg_pready(cfg_pready)
);

FILE: dv/hse_mac_checker.sv
// ----------------------------------------------------------------------------
// hse_mac_checker: MAC prediction and comparison for the HMAC-SHA256 engine
// Watches the input and result channels, keeps its own copy of the key
// registers and the hash state, and checks every result word in order.
// ----------------------------------------------------------------------------
module hse_mac_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  hse_in_if.monitor                    in_mon,
  hse_out_if.monitor                   out_mon,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic                         cfg_pready,
  input  logic [hse_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [hse_pkg::CfgDataW-1:0] cfg_pwdata,
  output int                           fail_count,
  output int                           mac_words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    hse_pkg::word_t mac_word;
    logic [2:0]     word_index;
    logic           last_word;
  } mac_beat_t;

  logic [63:0]    key_shadow [8];
  hse_pkg::word_t hash_state [8];
  logic [7:0]     msg_block  [64];
  logic [63:0]    byte_total;
  logic           msg_open;
  mac_beat_t      mac_queue [$];

  assign mac_words_pending = mac_queue.size();

  function automatic hse_pkg::word_t rotr(hse_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of a 64-byte block into hash_state.
  task automatic sha_compress(input logic [7:0] blk [64]);
    hse_pkg::word_t w [64];
    hse_pkg::word_t v [8];
    hse_pkg::word_t t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + hse_pkg::RoundK[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  // Restart from the initial value and absorb the padded key block.
  task automatic absorb_key_pad(input logic [7:0] pad);
    logic [7:0] blk [64];
    for (int i = 0; i < 64; i++)
      blk[i] = key_shadow[i/8][63-8*(i%8) -: 8] ^ pad;
    hash_state = hse_pkg::StartValue;
    sha_compress(blk);
  endtask

  // Work out the effect of one accepted input beat.
  task automatic predict_mac(input logic [7:0] data, input logic present,
                             input logic last);
    logic [7:0]  blk [64];
    logic [63:0] bits;
    int          used;
    if (!present && !last) return;
    if (!msg_open) begin
      absorb_key_pad(hse_pkg::IpadByte);
      byte_total = 64'd64;
      msg_open   = 1'b1;
    end
    if (present) begin
      msg_block[byte_total[5:0]] = data;
      byte_total++;
      if (byte_total[5:0] == 6'd0) sha_compress(msg_block);
    end
    if (!last) return;
    // Inner padding, with a second block when the length does not fit.
    used = int'(byte_total[5:0]);
    msg_block[used] = hse_pkg::PadByte;
    for (int i = used + 1; i < 64; i++) msg_block[i] = 8'h00;
    if (used >= 56) begin
      sha_compress(msg_block);
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    end
    bits = byte_total << 3;
    for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
    sha_compress(msg_block);
    // Outer hash over the 32-byte inner digest.
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 4; j++) blk[4*i+j] = hash_state[i][31-8*j -: 8];
    blk[32] = hse_pkg::PadByte;
    blk[62] = 8'h03;
    absorb_key_pad(hse_pkg::OpadByte);
    sha_compress(blk);
    for (int i = 0; i < 8; i++)
      mac_queue.push_back('{hash_state[i], 3'(i), i == 7});
    msg_open = 1'b0;
  endtask

  always @(posedge clk) begin
    mac_beat_t exp_beat;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) key_shadow[i] = '0;
      byte_total = '0;
      msg_open   = 1'b0;
      fail_count <= 0;
      mac_queue.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        key_shadow[cfg_paddr[5:3]] = cfg_pwdata;
      if (in_mon.valid && in_mon.ready)
        predict_mac(in_mon.data_byte, in_mon.byte_present, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) begin
        if (mac_queue.size() == 0) begin
          $error("unexpected MAC beat: mac_word %h", out_mon.mac_word);
          errs++;
        end else begin
          exp_beat = mac_queue.pop_front();
          if (out_mon.mac_word !== exp_beat.mac_word) begin
            $error("mac_word: expected %h, actual %h", exp_beat.mac_word,
                   out_mon.mac_word);
            errs++;
          end
          if (out_mon.word_index !== exp_beat.word_index) begin
            $error("word_index: expected %0d, actual %0d", exp_beat.word_index,
                   out_mon.word_index);
            errs++;
          end
          if (out_mon.last_word !== exp_beat.last_word) begin
            $error("last_word: expected %0d, actual %0d", exp_beat.last_word,
                   out_mon.last_word);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

FILE: dv/tb_hmac_sha256_engine_top.sv
// ----------------------------------------------------------------------------
// tb_hmac_sha256_engine_top: stimulus and verdict for the HMAC-SHA256 engine
// Programs keys over the register port, streams directed and random messages
// with random gaps and result stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_hmac_sha256_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_psel = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite = 1'b0;
  logic [hse_pkg::CfgAddrW-1:0] cfg_paddr = '0;
  logic [hse_pkg::CfgDataW-1:0] cfg_pwdata = '0;
  logic [hse_pkg::CfgDataW-1:0] cfg_prdata;
  logic                         cfg_pready;
  int                           fail_count;
  int                           mac_words_pending;
  int                           cycle_count = 0;
  bit                           gaps_on = 1'b1;

  hse_in_if  in_ch ();
  hse_out_if out_ch ();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hmac_sha256_engine_top i_dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  hse_mac_checker i_checker (
    .clk, .rst_n, .in_mon(in_ch.monitor), .out_mon(out_ch.monitor),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .fail_count, .mac_words_pending
  );

  // Result side stalls at random except during the quiet stretch.
  always @(posedge clk) begin
    out_ch.ready <= rst_n && (!gaps_on || $urandom_range(99) >= 25);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_key(input int idx, input logic [63:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx[2:0], 3'b000}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Wait for all MAC words, then the engine's tail latency.
  task automatic drain_macs();
    @(posedge clk);
    while (mac_words_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic load_keys(input int mode);
    logic [63:0] value;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: value = '0;
        1: value = '1;
        default: value = {$urandom, $urandom};
      endcase
      write_key(i, value);
    end
  endtask

  // Send one beat, holding valid until it is accepted.
  task automatic send_beat(input logic [7:0] data, input logic present,
                           input logic last);
    while (gaps_on && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.byte_present <= present;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_beat(8'($urandom), 1'b1, i == len - 1);
    if (len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.last_byte = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset key, empty message, idle beats, extremes of bytes.
    send_beat(8'hff, 1'b0, 1'b0);
    send_message(0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b0);
    send_beat(8'hff, 1'b1, 1'b1);
    in_ch.valid <= 1'b0;
    drain_macs();

    // A full block, then a tail that needs its own length block, no idling.
    load_keys(1);
    gaps_on = 1'b0;
    send_message(120);
    gaps_on = 1'b1;
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    in_ch.valid <= 1'b0;
    drain_macs();
    load_keys(2);

    // Short random messages with random and zero keys.
    for (int m = 0; m < 6; m++) begin
      len = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
        send_beat(8'($urandom), 1'b1, 1'b0);
      end
      send_beat(8'($urandom), 1'($urandom_range(1)), 1'b1);
      if (m == 2) begin
        in_ch.valid <= 1'b0;
        drain_macs();
        load_keys(0);
      end
    end
    in_ch.valid <= 1'b0;
    drain_macs();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
